### design/call_tree_time_profiler_macros.svh
// Assertion macros for the call-tree profiler RTL.
`ifndef CALL_TREE_TIME_PROFILER_MACROS_SVH
`define CALL_TREE_TIME_PROFILER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off during rst.
`define CTP_ASSERT_IMPLIES(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("call-tree profiler check failed");
// Next-cycle implication, sampled on clk, off during rst.
`define CTP_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("call-tree profiler check failed");
`else
`define CTP_ASSERT_IMPLIES(lbl, pre, post)
`define CTP_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

### design/ctp_pkg.sv
// Package with command and status codes and the request and response words.
package ctp_pkg;

  // Command codes
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_PUSH  = 2'd1;
  localparam logic [1:0] CMD_POP   = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  // Status codes
  localparam logic [2:0] ST_OK            = 3'd0;
  localparam logic [2:0] ST_TABLE_FULL    = 3'd1;
  localparam logic [2:0] ST_CHILDREN_FULL = 3'd2;
  localparam logic [2:0] ST_POP_ROOT      = 3'd3;
  localparam logic [2:0] ST_BAD_INDEX     = 3'd4;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] section_id;
    logic [15:0] timestamp;
    logic [5:0]  node_index;
  } req_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  current_node;
    logic [31:0] node_total;
    logic [15:0] node_section;
    logic [5:0]  node_parent;
    logic [3:0]  node_children;
  } rsp_word_t;

endpackage

### design/ctp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ctp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/call_tree_time_profiler.sv
// Top level of the call-tree time profiler: sequencer, tree stores and response register.
//
// Usage: drive a request word and raise start; the word is taken at a rising edge where
// start is high and busy is low. busy then stays high until the response is out. The
// response word appears on response for exactly one cycle, marked by done; the receiver
// cannot stall it and must take it in that cycle. One response per request.
// Commands: start clears the tree to the root and latches the timestamp; push charges the
// elapsed 16-bit time to the current node and enters or creates a child; pop charges
// time and returns to the parent; read reports one node. A push that fails on a full table
// or a full child list changes neither the tree nor the stored time.
// Start, a failed read and a pop at the root answer from dispatch; a good read answers from
// the read-done state and a pop from the pop-update state. A push reads the child count,
// then compares the children one at a time, reading the link store and then the section
// store for each, and on a miss checks for room and creates the node. The next request
// can be taken in the cycle done is high.
// Reset: the tree holds only the root, the current node is the root, the stored time
// is zero; the node stores themselves are not cleared, issue start before other commands.
module call_tree_time_profiler #(
  parameter int MAX_NODES    = 64,
  parameter int MAX_CHILDREN = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  ctp_pkg::req_word_t request,
  output logic              busy,
  output logic              done,
  output ctp_pkg::rsp_word_t response
);

  import ctp_pkg::*;

  `include "call_tree_time_profiler_macros.svh"

  localparam int NW  = $clog2(MAX_NODES);
  localparam int UW  = $clog2(MAX_NODES + 1);
  localparam int CCW = $clog2(MAX_CHILDREN + 1);
  localparam int LD  = MAX_NODES * MAX_CHILDREN;
  localparam int LW  = $clog2(LD);
  localparam int CW  = (UW > 6) ? UW : 6;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_READ_DONE,
    S_POP_UPD,
    S_PUSH_CNT,
    S_SEC,
    S_CMP,
    S_MISS,
    S_NEW2
  } state_t;

  state_t           state;
  req_word_t        req;
  logic [NW-1:0]    cur;
  logic [UW-1:0]    used;
  logic [15:0]      prev;
  logic [CCW-1:0]   cnt_q;
  logic [CCW-1:0]   ci;
  logic [31:0]      tot_q;
  logic [NW-1:0]    link_q;

  // Combinational helpers
  logic [15:0]      delta;
  logic [NW-1:0]    rd_idx;
  logic [NW-1:0]    fresh;
  logic [CCW-1:0]   ci_inc;
  logic [CCW-1:0]   link_sel;
  logic [LW-1:0]    link_base;
  logic [LW-1:0]    link_raddr;
  logic [LW-1:0]    link_waddr;
  logic [31:0]      sum;
  logic             match;
  logic             table_full;
  logic             kids_full;
  logic             read_ok;

  // Store ports
  logic             sec_we, tot_we, par_we, cnt_we, link_we;
  logic [NW-1:0]    sec_waddr, tot_waddr, par_waddr, cnt_waddr;
  logic [15:0]      sec_wdata;
  logic [31:0]      tot_wdata;
  logic [NW-1:0]    par_wdata;
  logic [CCW-1:0]   cnt_wdata;
  logic [NW-1:0]    sec_raddr;
  logic [15:0]      sec_rd;
  logic [31:0]      tot_rd;
  logic [NW-1:0]    par_rd;
  logic [CCW-1:0]   cnt_rd;
  logic [NW-1:0]    link_rd;

  function automatic rsp_word_t make_rsp(input logic [2:0] st, input logic [5:0] node);
    rsp_word_t r;
    r               = '0;
    r.status        = st;
    r.current_node  = node;
    return r;
  endfunction

  // Derive addresses, elapsed time and decisions
  assign delta      = req.timestamp - prev;
  assign rd_idx     = (req.command == CMD_READ) ? NW'(req.node_index) : cur;
  assign fresh      = NW'(used);
  assign ci_inc     = ci + CCW'(1);
  assign link_sel   = (state == S_CMP) ? ci_inc : ci;
  assign link_base  = LW'(cur) * LW'(MAX_CHILDREN);
  assign link_raddr = link_base + LW'(link_sel);
  assign link_waddr = link_base + LW'(cnt_q);
  assign sum        = ((state == S_POP_UPD) ? tot_rd : tot_q) + 32'(delta);
  assign match      = (sec_rd == req.section_id);
  assign table_full = (used >= UW'(MAX_NODES));
  assign kids_full  = (cnt_q >= CCW'(MAX_CHILDREN));
  assign read_ok    = (CW'(req.node_index) < CW'(used));
  assign sec_raddr  = (state == S_SEC) ? link_rd : rd_idx;

  // Steer store writes
  always_comb begin
    sec_we    = 1'b0;  sec_waddr = '0;  sec_wdata = '0;
    tot_we    = 1'b0;  tot_waddr = '0;  tot_wdata = '0;
    par_we    = 1'b0;  par_waddr = '0;  par_wdata = '0;
    cnt_we    = 1'b0;  cnt_waddr = '0;  cnt_wdata = '0;
    link_we   = 1'b0;
    case (state)
      S_DISPATCH: begin
        if (req.command == CMD_START) begin
          sec_we = 1'b1;
          tot_we = 1'b1;
          par_we = 1'b1;
          cnt_we = 1'b1;
        end
      end
      S_POP_UPD: begin
        tot_we    = 1'b1;
        tot_waddr = cur;
        tot_wdata = sum;
      end
      S_CMP: begin
        tot_we    = match;
        tot_waddr = cur;
        tot_wdata = sum;
      end
      S_MISS: begin
        if (!table_full && !kids_full) begin
          sec_we    = 1'b1;
          sec_waddr = fresh;
          sec_wdata = req.section_id;
          tot_we    = 1'b1;
          tot_waddr = cur;
          tot_wdata = sum;
          par_we    = 1'b1;
          par_waddr = fresh;
          par_wdata = cur;
          cnt_we    = 1'b1;
          cnt_waddr = cur;
          cnt_wdata = cnt_q + CCW'(1);
          link_we   = 1'b1;
        end
      end
      S_NEW2: begin
        tot_we    = 1'b1;
        tot_waddr = fresh;
        cnt_we    = 1'b1;
        cnt_waddr = fresh;
      end
      default: begin
      end
    endcase
  end

  // Tree stores
  ctp_ram #(.WIDTH(16), .DEPTH(MAX_NODES)) u_section (
    .clk(clk), .we(sec_we), .waddr(sec_waddr), .wdata(sec_wdata),
    .raddr(sec_raddr), .rdata(sec_rd)
  );

  ctp_ram #(.WIDTH(32), .DEPTH(MAX_NODES)) u_total (
    .clk(clk), .we(tot_we), .waddr(tot_waddr), .wdata(tot_wdata),
    .raddr(rd_idx), .rdata(tot_rd)
  );

  ctp_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_parent (
    .clk(clk), .we(par_we), .waddr(par_waddr), .wdata(par_wdata),
    .raddr(rd_idx), .rdata(par_rd)
  );

  ctp_ram #(.WIDTH(CCW), .DEPTH(MAX_NODES)) u_count (
    .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
    .raddr(rd_idx), .rdata(cnt_rd)
  );

  ctp_ram #(.WIDTH(NW), .DEPTH(LD)) u_link (
    .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(fresh),
    .raddr(link_raddr), .rdata(link_rd)
  );

  // Sequencer, tree registers and response word
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
      used  <= UW'(1);
      cur   <= '0;
      prev  <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            req   <= request;
            busy  <= 1'b1;
            ci    <= '0;
            state <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          case (req.command)
            CMD_START: begin
              used     <= UW'(1);
              cur      <= '0;
              prev     <= req.timestamp;
              response <= make_rsp(ST_OK, 6'd0);
              done     <= 1'b1;
              busy     <= 1'b0;
              state    <= S_IDLE;
            end
            CMD_PUSH: begin
              state <= S_PUSH_CNT;
            end
            CMD_POP: begin
              if (cur == '0) begin
                response <= make_rsp(ST_POP_ROOT, 6'(cur));
                done     <= 1'b1;
                busy     <= 1'b0;
                state    <= S_IDLE;
              end else begin
                state <= S_POP_UPD;
              end
            end
            default: begin
              if (read_ok) begin
                state <= S_READ_DONE;
              end else begin
                response <= make_rsp(ST_BAD_INDEX, 6'(cur));
                done     <= 1'b1;
                busy     <= 1'b0;
                state    <= S_IDLE;
              end
            end
          endcase
        end
        S_READ_DONE: begin
          response.status        <= ST_OK;
          response.current_node  <= 6'(cur);
          response.node_total    <= tot_rd;
          response.node_section  <= sec_rd;
          response.node_parent   <= (req.node_index == 6'd0) ? 6'd0 : 6'(par_rd);
          response.node_children <= 4'(cnt_rd);
          done                   <= 1'b1;
          busy                   <= 1'b0;
          state                  <= S_IDLE;
        end
        S_POP_UPD: begin
          cur      <= par_rd;
          prev     <= req.timestamp;
          response <= make_rsp(ST_OK, 6'(par_rd));
          done     <= 1'b1;
          busy     <= 1'b0;
          state    <= S_IDLE;
        end
        S_PUSH_CNT: begin
          cnt_q <= cnt_rd;
          tot_q <= tot_rd;
          state <= (cnt_rd == '0) ? S_MISS : S_SEC;
        end
        S_SEC: begin
          link_q <= link_rd;
          state  <= S_CMP;
        end
        S_CMP: begin
          if (match) begin
            cur      <= link_q;
            prev     <= req.timestamp;
            response <= make_rsp(ST_OK, 6'(link_q));
            done     <= 1'b1;
            busy     <= 1'b0;
            state    <= S_IDLE;
          end else if (ci_inc == cnt_q) begin
            state <= S_MISS;
          end else begin
            ci    <= ci_inc;
            state <= S_SEC;
          end
        end
        S_MISS: begin
          if (table_full) begin
            response <= make_rsp(ST_TABLE_FULL, 6'(cur));
            done     <= 1'b1;
            busy     <= 1'b0;
            state    <= S_IDLE;
          end else if (kids_full) begin
            response <= make_rsp(ST_CHILDREN_FULL, 6'(cur));
            done     <= 1'b1;
            busy     <= 1'b0;
            state    <= S_IDLE;
          end else begin
            prev  <= req.timestamp;
            state <= S_NEW2;
          end
        end
        S_NEW2: begin
          used     <= used + UW'(1);
          cur      <= fresh;
          response <= make_rsp(ST_OK, 6'(fresh));
          done     <= 1'b1;
          busy     <= 1'b0;
          state    <= S_IDLE;
        end
        default: begin
          busy  <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Checks on the sequencer and tree registers
  `CTP_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `CTP_ASSERT_IMPLIES(a_done_idle, done, !busy && state == S_IDLE)
  `CTP_ASSERT_NEXT(a_done_pulse, done, !done)
  `CTP_ASSERT_IMPLIES(a_used_range, 1'b1, used != '0 && used <= UW'(MAX_NODES))
  `CTP_ASSERT_IMPLIES(a_err_keeps_cur, done && response.status != ST_OK, $stable(cur))

endmodule
